// ===== rtl/rwsn_pkg.sv =====
// Shared types and codes for the ring work-stealing node.
// No dependencies; imported by every module of the block.
`default_nettype none

package rwsn_pkg;

  // Ring message kinds
  localparam logic [1:0] KIND_FINALIZE = 2'd0;
  localparam logic [1:0] KIND_REQUEST  = 2'd1;
  localparam logic [1:0] KIND_TASK     = 2'd2;

  // Input commands
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_POLL = 2'd2;
  localparam logic [1:0] CMD_MSG  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_NODE_RANK      = 2'd0;
  localparam logic [1:0] CFG_NODE_TOTAL     = 2'd1;
  localparam logic [1:0] CFG_STEAL_DISABLED = 2'd2;

  // Classified operations passed from front to back
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_POP,
    OP_POLL,
    OP_MSG_FIN,
    OP_MSG_REQ,
    OP_MSG_TASK,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         code;
    logic        own_req;   // request payload equals this node's rank
    logic [15:0] payload;
  } op_t;

  // Configuration seen by front and back
  typedef struct packed {
    logic [3:0] rank;
    logic [3:0] next_rank;
    logic       steal_disabled;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic        send_valid;
    logic [1:0]  send_kind;
    logic [3:0]  send_dest;
    logic [15:0] send_payload;
    logic        task_valid;
    logic [15:0] task_number;
    logic        done_res;
    logic        overflow;
  } res_t;

  // Outstanding queue read in the back end
  typedef struct packed {
    logic       to_ring;    // 1: answer a request with a task, 0: worker pop
    logic [3:0] dest;
  } pend_t;

  typedef enum logic [1:0] {
    CFG_IDLE,
    CFG_LOAD,
    CFG_DIV
  } cfg_state_e;

  typedef enum logic {
    BK_EXEC,
    BK_READ
  } bk_state_e;

endpackage

`default_nettype wire

// ===== rtl/rwsn_cfg.sv =====
// Configuration registers and next-rank unit of the ring node.
// Depends on rwsn_pkg; next rank is found by repeated subtraction.
`default_nettype none

module rwsn_cfg #(
  parameter int unsigned MAX_NODES = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_addr_i,
  input  wire logic [4:0]   cfg_wdata_i,
  output rwsn_pkg::cfg_t    cfg_o,
  output logic              busy_o
);
  import rwsn_pkg::*;

  localparam int unsigned MaxClamp = (MAX_NODES > 31) ? 31 : MAX_NODES;

  logic [3:0] rank_q;
  logic [4:0] total_q;
  logic       steal_dis_q;
  logic [3:0] next_q, next_d;
  logic [4:0] rem_q, rem_d;
  logic [4:0] eff_total;
  cfg_state_e state_q, state_d;

  // Write the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q      <= '0;
      total_q     <= 5'd1;
      steal_dis_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_NODE_RANK:      rank_q      <= cfg_wdata_i[3:0];
        CFG_NODE_TOTAL:     total_q     <= cfg_wdata_i;
        CFG_STEAL_DISABLED: steal_dis_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Clamp ring size into one to MAX_NODES, but never above 31
  always_comb begin
    if (total_q == 5'd0) begin
      eff_total = 5'd1;
    end else if (total_q > 5'(MaxClamp)) begin
      eff_total = 5'(MaxClamp);
    end else begin
      eff_total = total_q;
    end
  end

  // Next rank: subtract ring size from rank+1 until below it
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    next_d  = next_q;
    unique case (state_q)
      CFG_IDLE: ;
      CFG_LOAD: begin
        rem_d   = {1'b0, rank_q} + 5'd1;
        state_d = CFG_DIV;
      end
      CFG_DIV: begin
        if (rem_q >= eff_total) begin
          rem_d = rem_q - eff_total;
        end else begin
          next_d  = rem_q[3:0];
          state_d = CFG_IDLE;
        end
      end
      default: state_d = CFG_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = CFG_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CFG_IDLE;
      next_q  <= '0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign busy_o               = (state_q != CFG_IDLE);
  assign cfg_o.rank           = rank_q;
  assign cfg_o.next_rank      = next_q;
  assign cfg_o.steal_disabled = steal_dis_q;

endmodule

`default_nettype wire

// ===== rtl/rwsn_front.sv =====
// Front end of the ring node: accepts and classifies input transactions.
// Depends on rwsn_pkg; holds a two-entry operation queue for the back end.
`default_nettype none

module rwsn_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic          busy_i,
  input  wire logic [1:0]    command_i,
  input  wire logic [1:0]    msg_kind_i,
  input  wire logic [15:0]   payload_i,
  input  wire rwsn_pkg::cfg_t cfg_i,
  input  wire logic          op_pop_i,
  output logic               full_o,
  output logic               op_valid_o,
  output rwsn_pkg::op_t      op_o
);
  import rwsn_pkg::*;

  op_t        oq_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  op_t        op_new;
  logic       acc;

  assign full_o = (cnt_q == 2'd2) || busy_i;
  assign acc    = push_i && !full_o;

  // Classify the command
  always_comb begin
    op_new.payload = payload_i;
    op_new.own_req = (payload_i == {12'd0, cfg_i.rank});
    op_new.code    = OP_NOP;
    unique case (command_i)
      CMD_LOAD: op_new.code = OP_LOAD;
      CMD_POP:  op_new.code = OP_POP;
      CMD_POLL: op_new.code = OP_POLL;
      CMD_MSG: begin
        unique case (msg_kind_i)
          KIND_FINALIZE: op_new.code = OP_MSG_FIN;
          KIND_REQUEST:  op_new.code = OP_MSG_REQ;
          KIND_TASK:     op_new.code = OP_MSG_TASK;
          default:       op_new.code = OP_NOP;
        endcase
      end
      default: op_new.code = OP_NOP;
    endcase
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (acc) begin
      oq_q[wptr_q] <= op_new;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (acc) begin
        wptr_q <= ~wptr_q;
      end
      if (op_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, op_pop_i};
    end
  end

  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = oq_q[rptr_q];

endmodule

`default_nettype wire

// ===== rtl/rwsn_back.sv =====
// Back end of the ring node: task queue memory, node flags, result queue.
// Depends on rwsn_pkg; pops and task answers go through a registered memory read.
`default_nettype none

module rwsn_back #(
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned TASK_BITS   = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rwsn_pkg::cfg_t cfg_i,
  input  wire logic          op_valid_i,
  input  wire rwsn_pkg::op_t op_i,
  output logic               op_pop_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output rwsn_pkg::res_t     res_o
);
  import rwsn_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [TASK_BITS-1:0] mem [QUEUE_DEPTH];
  logic [TASK_BITS-1:0] rdata_q;
  logic [AW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 req_q, req_d, fin_q, fin_d;
  pend_t                pend_q, pend_d;
  bk_state_e            state_q, state_d;
  logic                 mem_we, mem_re, q_full, q_empty, live;
  logic                 res_push, res_full;
  res_t                 res;

  res_t                 rq_q [2];
  logic                 rwp_q, rrp_q;
  logic [1:0]           rcnt_q;
  logic                 res_pop;

  assign q_full   = (count_q == CW'(QUEUE_DEPTH));
  assign q_empty  = (count_q == '0);
  assign live     = !fin_q && !cfg_i.steal_disabled;
  assign res_full = (rcnt_q == 2'd2);

  // Execute one operation
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    req_d    = req_q;
    fin_d    = fin_q;
    pend_d   = pend_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    op_pop_o = 1'b0;
    res_push = 1'b0;
    res      = '0;
    unique case (state_q)
      BK_EXEC: begin
        if (op_valid_i && !res_full) begin
          op_pop_o = 1'b1;
          res_push = 1'b1;
          unique case (op_i.code)
            OP_LOAD: begin
              if (q_full) begin
                res.overflow = 1'b1;
              end else begin
                mem_we  = 1'b1;
                tail_d  = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (!fin_q && !q_empty) begin
                res_push = 1'b0;
                mem_re   = 1'b1;
                pend_d   = '{to_ring: 1'b0, dest: 4'd0};
                state_d  = BK_READ;
              end
            end
            OP_POLL: begin
              if (!fin_q) begin
                if (cfg_i.steal_disabled) begin
                  if (q_empty) begin
                    fin_d = 1'b1;
                  end
                end else if (q_empty && !req_q) begin
                  res.send_valid   = 1'b1;
                  res.send_kind    = KIND_REQUEST;
                  res.send_dest    = cfg_i.next_rank;
                  res.send_payload = {12'd0, cfg_i.rank};
                  req_d            = 1'b1;
                end
              end
            end
            OP_MSG_FIN: begin
              if (live) begin
                res.send_valid   = 1'b1;
                res.send_kind    = KIND_FINALIZE;
                res.send_dest    = cfg_i.next_rank;
                res.send_payload = op_i.payload;
                fin_d            = 1'b1;
              end
            end
            OP_MSG_REQ: begin
              if (live) begin
                priority if (op_i.own_req) begin
                  fin_d            = 1'b1;
                  res.send_valid   = 1'b1;
                  res.send_kind    = KIND_FINALIZE;
                  res.send_dest    = cfg_i.next_rank;
                  res.send_payload = {12'd0, cfg_i.rank};
                end else if (!q_empty) begin
                  res_push = 1'b0;
                  mem_re   = 1'b1;
                  pend_d   = '{to_ring: 1'b1, dest: op_i.payload[3:0]};
                  state_d  = BK_READ;
                end else begin
                  res.send_valid   = 1'b1;
                  res.send_kind    = KIND_REQUEST;
                  res.send_dest    = cfg_i.next_rank;
                  res.send_payload = op_i.payload;
                end
              end
            end
            OP_MSG_TASK: begin
              if (live) begin
                if (q_full) begin
                  res.overflow = 1'b1;
                end else begin
                  mem_we  = 1'b1;
                  tail_d  = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                  count_d = count_q + 1'b1;
                end
                req_d = 1'b0;
              end
            end
            default: ;
          endcase
          // Hand the head entry out on a read
          if (mem_re) begin
            head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_d = count_q - 1'b1;
          end
        end
      end
      BK_READ: begin
        res_push = 1'b1;
        state_d  = BK_EXEC;
        if (pend_q.to_ring) begin
          res.send_valid   = 1'b1;
          res.send_kind    = KIND_TASK;
          res.send_dest    = pend_q.dest;
          res.send_payload = 16'(rdata_q);
        end else begin
          res.task_valid  = 1'b1;
          res.task_number = 16'(rdata_q);
        end
      end
      default: state_d = BK_EXEC;
    endcase
    res.done_res = fin_d;
  end

  // Task memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= TASK_BITS'(op_i.payload);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[head_q];
    end
  end

  // Hold node state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_EXEC;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      req_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      req_q   <= req_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // Result queue
  assign res_pop = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rq_q[rwp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwp_q  <= 1'b0;
      rrp_q  <= 1'b0;
      rcnt_q <= '0;
    end else begin
      if (res_push) begin
        rwp_q <= ~rwp_q;
      end
      if (res_pop) begin
        rrp_q <= ~rrp_q;
      end
      rcnt_q <= rcnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  assign empty_o = (rcnt_q == 2'd0);
  assign res_o   = rq_q[rrp_q];

endmodule

`default_nettype wire

// ===== rtl/ring_work_stealing_node.sv =====
// Top level of one work-stealing ring node.
// Depends on rwsn_pkg, rwsn_cfg, rwsn_front and rwsn_back.
//
//   Channel   Handshake                  Payload
//   input     push / full                command_i, msg_kind_i, payload_i
//   result    empty / pop                send_*_o, task_*_o, done_res_o, overflow_o
//   config    cfg_we_i (no wait)         cfg_addr_i, cfg_wdata_i
//
// One transaction per cycle for loads, polls and messages while the result queue
// has room; one that takes a task off the queue waits for the registered memory read.
// The front queue holds two transactions, the result queue two more.
// After each configuration write, full stays high while the next ring rank
// is worked out by repeated subtraction.
// The task memory has no reset; pointers, counts, state, flags and config registers are cleared.
`default_nettype none

module ring_work_stealing_node #(
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned MAX_NODES   = 16,
  parameter int unsigned TASK_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  command_i,
  input  wire logic [1:0]  msg_kind_i,
  input  wire logic [15:0] payload_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             send_valid_o,
  output logic [1:0]       send_kind_o,
  output logic [3:0]       send_dest_o,
  output logic [15:0]      send_payload_o,
  output logic             task_valid_o,
  output logic [15:0]      task_number_o,
  output logic             done_res_o,
  output logic             overflow_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [4:0]  cfg_wdata_i
);
  import rwsn_pkg::*;

  cfg_t cfg;
  logic busy, op_valid, op_pop;
  op_t  op;
  res_t res;

  rwsn_cfg #(
    .MAX_NODES (MAX_NODES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .busy_o      (busy)
  );

  rwsn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .busy_i     (busy),
    .command_i  (command_i),
    .msg_kind_i (msg_kind_i),
    .payload_i  (payload_i),
    .cfg_i      (cfg),
    .op_pop_i   (op_pop),
    .full_o     (full),
    .op_valid_o (op_valid),
    .op_o       (op)
  );

  rwsn_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_BITS   (TASK_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign send_valid_o   = res.send_valid;
  assign send_kind_o    = res.send_kind;
  assign send_dest_o    = res.send_dest;
  assign send_payload_o = res.send_payload;
  assign task_valid_o   = res.task_valid;
  assign task_number_o  = res.task_number;
  assign done_res_o     = res.done_res;
  assign overflow_o     = res.overflow;

endmodule

`default_nettype wire

// ===== test/ring_work_stealing_node_tb.sv =====
// Self-checking testbench for ring_work_stealing_node: directed and random command traffic
// with bursty input and a stalling result side, checked against an in-bench predictor.
// Depends on rwsn_pkg and the ring_work_stealing_node RTL.
`default_nettype none

module ring_work_stealing_node_tb;
  import rwsn_pkg::*;

  localparam int TASK_DEPTH = 256;
  localparam int RING_MAX   = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  command_i;
  logic [1:0]  msg_kind_i;
  logic [15:0] payload_i;
  logic        empty;
  logic        pop;
  logic        send_valid_o;
  logic [1:0]  send_kind_o;
  logic [3:0]  send_dest_o;
  logic [15:0] send_payload_o;
  logic        task_valid_o;
  logic [15:0] task_number_o;
  logic        done_res_o;
  logic        overflow_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [4:0]  cfg_wdata_i;

  ring_work_stealing_node dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .msg_kind_i     (msg_kind_i),
    .payload_i      (payload_i),
    .empty          (empty),
    .pop            (pop),
    .send_valid_o   (send_valid_o),
    .send_kind_o    (send_kind_o),
    .send_dest_o    (send_dest_o),
    .send_payload_o (send_payload_o),
    .task_valid_o   (task_valid_o),
    .task_number_o  (task_number_o),
    .done_res_o     (done_res_o),
    .overflow_o     (overflow_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Node state as predicted by the bench
  logic [15:0] node_tasks[$];
  logic        req_out;
  logic        node_done;
  logic [3:0]  cfg_rank;
  logic [4:0]  cfg_total;
  logic        cfg_no_steal;

  res_t outcome_q[$];
  int   mismatch_count;
  int   result_idx;
  int   burst_left;

  // Receiver stall pattern
  int   rx_mode;
  int   rx_cycle;
  int   rx_stall;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // End the run if the handshakes hang
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [3:0] next_hop();
    int total;
    total = cfg_total;
    if (total == 0) total = 1;
    if (total > RING_MAX) total = RING_MAX;
    next_hop = 4'((int'(cfg_rank) + 1) % total);
  endfunction

  function automatic logic store_task(logic [15:0] value);
    if (node_tasks.size() >= TASK_DEPTH) return 1'b0;
    node_tasks.push_back(value);
    return 1'b1;
  endfunction

  function automatic res_t predict_outcome(logic [1:0] cmd, logic [1:0] kind,
                                           logic [15:0] pay);
    res_t r;
    r = '0;
    case (cmd)
      CMD_LOAD: r.overflow = !store_task(pay);
      CMD_POP: begin
        if (!node_done && node_tasks.size() > 0) begin
          r.task_valid  = 1'b1;
          r.task_number = node_tasks.pop_front();
        end
      end
      CMD_POLL: begin
        if (!node_done) begin
          if (cfg_no_steal) begin
            if (node_tasks.size() == 0) node_done = 1'b1;
          end else if (node_tasks.size() == 0 && !req_out) begin
            r.send_valid   = 1'b1;
            r.send_kind    = KIND_REQUEST;
            r.send_dest    = next_hop();
            r.send_payload = {12'd0, cfg_rank};
            req_out        = 1'b1;
          end
        end
      end
      default: begin
        if (!node_done && !cfg_no_steal) begin
          case (kind)
            KIND_FINALIZE: begin
              r.send_valid   = 1'b1;
              r.send_kind    = KIND_FINALIZE;
              r.send_dest    = next_hop();
              r.send_payload = pay;
              node_done      = 1'b1;
            end
            KIND_REQUEST: begin
              r.send_valid = 1'b1;
              if (pay == {12'd0, cfg_rank}) begin
                // own request came round the ring: start the finalize wave
                r.send_kind    = KIND_FINALIZE;
                r.send_dest    = next_hop();
                r.send_payload = {12'd0, cfg_rank};
                node_done      = 1'b1;
              end else if (node_tasks.size() > 0) begin
                r.send_kind    = KIND_TASK;
                r.send_dest    = pay[3:0];
                r.send_payload = node_tasks.pop_front();
              end else begin
                r.send_kind    = KIND_REQUEST;
                r.send_dest    = next_hop();
                r.send_payload = pay;
              end
            end
            KIND_TASK: begin
              r.overflow = !store_task(pay);
              req_out    = 1'b0;
            end
            default: ;
          endcase
        end
      end
    endcase
    r.done_res = node_done;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got %h, want %h", result_idx, name, got, want));
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (outcome_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
      end else begin
        res_t want;
        want = outcome_q.pop_front();
        check_field("send_valid", 16'(send_valid_o), 16'(want.send_valid));
        check_field("send_kind", 16'(send_kind_o), 16'(want.send_kind));
        check_field("send_dest", 16'(send_dest_o), 16'(want.send_dest));
        check_field("send_payload", send_payload_o, want.send_payload);
        check_field("task_valid", 16'(task_valid_o), 16'(want.task_valid));
        check_field("task_number", task_number_o, want.task_number);
        check_field("done_res", 16'(done_res_o), 16'(want.done_res));
        check_field("overflow", 16'(overflow_o), 16'(want.overflow));
      end
      result_idx++;
    end
  end

  // Drive pop from a stall pattern that is picked anew at random
  always @(negedge clk_i) begin
    if (rx_cycle == 0) begin
      rx_mode  = $urandom_range(0, 3);
      rx_cycle = 40;
    end
    rx_cycle--;
    case (rx_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= (rx_cycle % 4 == 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
          if ($urandom_range(0, 2) == 0) rx_stall = $urandom_range(1, 7);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------- drivers

  // Send one transaction; entered and left at a falling edge
  task automatic send_command(input logic [1:0] cmd, input logic [1:0] kind,
                              input logic [15:0] pay);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    push       <= 1'b1;
    command_i  <= cmd;
    msg_kind_i <= kind;
    payload_i  <= pay;
    do @(posedge clk_i); while (full);
    outcome_q.push_back(predict_outcome(cmd, kind, pay));
    burst_left--;
    @(negedge clk_i);
  endtask

  // Hold the sender until every expected result has been taken
  task automatic wait_idle();
    push <= 1'b0;
    burst_left = 0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NODE_RANK:  cfg_rank  = data[3:0];
      CFG_NODE_TOTAL: cfg_total = data;
      default:        cfg_no_steal = data[0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [4:0] rank, input logic [4:0] total,
                           input logic no_steal);
    wait_idle();
    write_reg(CFG_NODE_RANK, rank);
    write_reg(CFG_NODE_TOTAL, total);
    write_reg(CFG_STEAL_DISABLED, {4'd0, no_steal});
  endtask

  // ---------------------------------------------------------------- tests

  // Reset configuration: single-node ring, stealing on
  task automatic test_reset_defaults();
    send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);  // request to self
    send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);  // request already out
    send_command(CMD_MSG, KIND_TASK, 16'hFFFF);       // answer clears request
    send_command(CMD_POP, KIND_FINALIZE, 16'h0000);
    send_command(CMD_POP, KIND_FINALIZE, 16'h0000);   // empty queue
    send_command(CMD_MSG, KIND_REQUEST, 16'h0003);    // forward, nothing to give
    send_command(CMD_MSG, 2'd3, 16'hFFFF);            // unknown kind
  endtask

  // Task answers, forwarding and ring sizes out of range
  task automatic test_ring_routing();
    configure(5'd15, 5'd16, 1'b0);
    send_command(CMD_LOAD, KIND_FINALIZE, 16'h0000);
    send_command(CMD_LOAD, KIND_FINALIZE, 16'hA5A5);
    send_command(CMD_MSG, KIND_REQUEST, 16'h0002);
    // low bits equal the rank but the full payload does not
    send_command(CMD_MSG, KIND_REQUEST, 16'h001F);
    send_command(CMD_MSG, KIND_REQUEST, 16'hFFF7);
    configure(5'd7, 5'd0, 1'b0);                      // zero ring size counts as one
    send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);
    configure(5'd7, 5'd31, 1'b0);                     // clamp to the largest ring
    send_command(CMD_MSG, KIND_TASK, 16'h8000);
    send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);
    send_command(CMD_POP, KIND_FINALIZE, 16'h0000);
    send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);
  endtask

  // With stealing disabled every ring message is dropped
  task automatic test_steal_disabled();
    configure(5'd2, 5'd4, 1'b1);
    send_command(CMD_MSG, KIND_REQUEST, 16'h0002);
    send_command(CMD_MSG, KIND_FINALIZE, 16'h1234);
    send_command(CMD_MSG, KIND_TASK, 16'h5555);
    send_command(CMD_LOAD, KIND_FINALIZE, 16'h0001);
    send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);
    send_command(CMD_POP, KIND_FINALIZE, 16'h0000);
  endtask

  // Fill the queue to the brim, then push past it
  task automatic test_queue_overflow();
    configure(5'd3, 5'd5, 1'b0);
    send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);
    while (node_tasks.size() < TASK_DEPTH)
      send_command(CMD_LOAD, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
    send_command(CMD_LOAD, KIND_FINALIZE, 16'h0F0F);
    send_command(CMD_LOAD, KIND_FINALIZE, 16'hF0F0);
    send_command(CMD_MSG, KIND_TASK, 16'h7777);       // dropped, still clears request
    send_command(CMD_POP, KIND_FINALIZE, 16'h0000);
    send_command(CMD_LOAD, KIND_FINALIZE, 16'h3C3C);
  endtask

  // Random traffic over several ring settings, never finishing the node
  task automatic test_random_traffic();
    logic [1:0]  cmd;
    logic [1:0]  kind;
    logic [15:0] pay;
    int          sel;
    int          load_w;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: configure(5'd0, 5'd16, 1'b0);
        1: configure(5'd15, 5'd31, 1'b0);
        2: configure(5'($urandom_range(0, 31)), 5'd0, 1'b1);
        default: configure(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                           ($urandom_range(0, 3) == 0));
      endcase
      for (int n = 0; n < 75; n++) begin
        // hold the sender once until the result side has drained
        if (phase == 1 && n == 40) wait_idle();
        load_w = (node_tasks.size() > 192) ? 8 : 30;
        sel  = $urandom_range(0, 99);
        kind = 2'($urandom_range(0, 3));
        pay  = 16'($urandom_range(0, 65535));
        if (sel < load_w) begin
          cmd = CMD_LOAD;
        end else if (sel < load_w + 25) begin
          cmd = CMD_POP;
        end else if (sel < load_w + 40) begin
          cmd = (cfg_no_steal && node_tasks.size() == 0) ? CMD_LOAD : CMD_POLL;
        end else begin
          cmd = CMD_MSG;
          sel = $urandom_range(0, 9);
          if (sel < 5) begin
            kind = KIND_REQUEST;
            if ($urandom_range(0, 9) < 6) pay = 16'($urandom_range(0, 15));
          end else if (sel < 8) begin
            kind = KIND_TASK;
          end else begin
            kind = cfg_no_steal ? KIND_FINALIZE : 2'd3;
          end
          // keep the node alive: no own request coming back while stealing
          if (!cfg_no_steal && kind == KIND_REQUEST && pay == {12'd0, cfg_rank})
            pay = pay | 16'h0100;
        end
        send_command(cmd, kind, pay);
      end
    end
  endtask

  // Finish the node by one of its three routes, then check it stays finished
  task automatic test_finish();
    int route;
    route = $urandom_range(0, 2);
    if (route == 2) begin
      configure(5'($urandom_range(0, 15)), 5'($urandom_range(1, 16)), 1'b1);
      while (node_tasks.size() > 0) send_command(CMD_POP, KIND_FINALIZE, 16'h0000);
      send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);
    end else begin
      configure(5'($urandom_range(0, 15)), 5'($urandom_range(0, 31)), 1'b0);
      if (route == 0)
        send_command(CMD_MSG, KIND_FINALIZE, 16'($urandom_range(0, 65535)));
      else
        send_command(CMD_MSG, KIND_REQUEST, {12'd0, cfg_rank});
    end
    send_command(CMD_LOAD, KIND_FINALIZE, 16'hBEEF);  // loads still land
    send_command(CMD_POP, KIND_FINALIZE, 16'h0000);
    send_command(CMD_POLL, KIND_FINALIZE, 16'h0000);
    send_command(CMD_MSG, KIND_TASK, 16'h1111);
    send_command(CMD_MSG, KIND_REQUEST, 16'h0009);
    send_command(CMD_MSG, KIND_FINALIZE, 16'h2222);
    send_command(CMD_MSG, 2'd3, 16'h3333);
    send_command(CMD_LOAD, KIND_FINALIZE, 16'h4444);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni         = 1'b0;
    push           = 1'b0;
    command_i      = CMD_LOAD;
    msg_kind_i     = KIND_FINALIZE;
    payload_i      = 16'h0000;
    pop            = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = CFG_NODE_RANK;
    cfg_wdata_i    = 5'd0;
    req_out        = 1'b0;
    node_done      = 1'b0;
    cfg_rank       = 4'd0;
    cfg_total      = 5'd1;
    cfg_no_steal   = 1'b0;
    mismatch_count = 0;
    result_idx     = 0;
    burst_left     = 0;
    rx_mode        = 0;
    rx_cycle       = 0;
    rx_stall       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_ring_routing();
    test_steal_disabled();
    test_queue_overflow();
    test_random_traffic();
    test_finish();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/rwsn_pkg.sv
rtl/rwsn_cfg.sv
rtl/rwsn_front.sv
rtl/rwsn_back.sv
rtl/ring_work_stealing_node.sv
test/ring_work_stealing_node_tb.sv
